>>> design/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types, character codes and helpers for the notation text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int ODATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_NOTE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OCTAVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CALL   = 3'd4;

  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D      = 8'h44;
  localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
  localparam logic [CHAR_W-1:0] CH_F      = 8'h46;
  localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h52;
  localparam logic [CHAR_W-1:0] CH_Z      = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LB     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  localparam logic signed [3:0] S4_MAX = 4'sd7;
  localparam logic signed [3:0] S4_MIN = -4'sd8;
  localparam logic [3:0]        U4_MAX = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic signed [5:0] pitch_value;
    logic signed [3:0] octave_shift;
    logic [3:0]        double_count;
    logic [3:0]        half_count;
    logic [3:0]        octave_number;
    logic              phrase_end;
    logic              accented;
    logic [7:0]        bad_char;
  } result_t;

  function automatic logic signed [3:0] sat_inc(input logic signed [3:0] v);
    return (v == S4_MAX) ? v : v + 4'sd1;
  endfunction

  function automatic logic signed [3:0] sat_dec(input logic signed [3:0] v);
    return (v == S4_MIN) ? v : v - 4'sd1;
  endfunction

  function automatic logic [3:0] usat_inc(input logic [3:0] v);
    return (v == U4_MAX) ? v : v + 4'd1;
  endfunction

  function automatic logic signed [5:0] letter_base(input logic [CHAR_W-1:0] c);
    logic signed [5:0] b;
    case (c)
      CH_C:    b = 6'sd0;
      CH_D:    b = 6'sd2;
      CH_E:    b = 6'sd4;
      CH_F:    b = 6'sd5;
      CH_G:    b = 6'sd7;
      CH_A:    b = 6'sd9;
      default: b = 6'sd11;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/note_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// note_text_tokenizer_top
// Tokenizes a music-notation character stream into note, rest, octave,
// function-call and unexpected-character tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transfer, in_tlast marks the final character
//           of a text; all pending marks are dropped after it.
//   out_* : one token per transfer; out_tuser carries the kind, out_tlast is
//           always high (a character causes at most one token).
//   Throughput: one character per cycle while in_tready is high. The decode
//   sits between the input ports and the output register; a skid register
//   behind it takes a token that arrives while the receiver stalls, which
//   keeps in_tready high while one token waits. in_tready drops only while
//   both output and skid registers are full.
//   Reset clears the pending record, the flat and call-skip flags and both
//   output slots.
// ----------------------------------------------------------------------------
`default_nettype none

module note_text_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_char
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [ntt_pkg::ODATA_W-1:0] out_tdata,
                                       // [5:0] pitch_value, [9:6] octave_shift,
                                       // [13:10] double_count, [17:14] half_count,
                                       // [21:18] octave_number, [22] phrase_end,
                                       // [23] accented, [31:24] bad_char
  output logic [2:0]       out_tuser,  // [2:0] token_kind
  output logic             out_tlast   // last
);

  logic signed [3:0] acc_r, acc_nxt;
  logic signed [3:0] shift_r, shift_nxt;
  logic [3:0]        dbl_r, dbl_nxt;
  logic [3:0]        half_r, half_nxt;
  logic              phrase_r, phrase_nxt;
  logic              accent_r, accent_nxt;
  logic              flat_r, flat_nxt;
  logic              skip_r, skip_nxt;

  ntt_pkg::result_t  res;
  logic              emit;
  ntt_pkg::result_t  out_r, skid_r;
  logic              out_valid_r, skid_valid_r;

  logic              in_xfer, out_xfer;
  logic [7:0]        c;
  logic              normal;

  assign c         = in_tdata;
  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  always_comb begin
    acc_nxt    = acc_r;
    shift_nxt  = shift_r;
    dbl_nxt    = dbl_r;
    half_nxt   = half_r;
    phrase_nxt = phrase_r;
    accent_nxt = accent_r;
    flat_nxt   = flat_r;
    skip_nxt   = skip_r;
    emit       = 1'b0;
    normal     = 1'b1;
    res        = '0;

    if (skip_r) begin
      normal = 1'b0;
      if (c == ntt_pkg::CH_RPAREN) begin
        emit           = 1'b1;
        res.token_kind = ntt_pkg::KIND_CALL;
        skip_nxt       = 1'b0;
      end
    end else if (flat_r) begin
      flat_nxt = 1'b0;
      if (c inside {[ntt_pkg::CH_A:ntt_pkg::CH_Z]}) begin
        acc_nxt = ntt_pkg::sat_dec(acc_r);
      end else begin
        normal = 1'b0;
        if (c == ntt_pkg::CH_RPAREN) begin
          emit           = 1'b1;
          res.token_kind = ntt_pkg::KIND_CALL;
        end else begin
          skip_nxt = 1'b1;
        end
      end
    end

    if (normal) begin
      if (c inside {[ntt_pkg::CH_A:ntt_pkg::CH_G]}) begin
        emit            = 1'b1;
        res.token_kind  = ntt_pkg::KIND_NOTE;
        res.pitch_value = ntt_pkg::letter_base(c) + 6'(acc_nxt);
      end else if (c == ntt_pkg::CH_R) begin
        emit           = 1'b1;
        res.token_kind = ntt_pkg::KIND_REST;
      end else if (c inside {[ntt_pkg::CH_0:ntt_pkg::CH_9]}) begin
        emit              = 1'b1;
        res.token_kind    = ntt_pkg::KIND_OCTAVE;
        res.octave_number = 4'(c - ntt_pkg::CH_0);
      end else if (c == ntt_pkg::CH_CARET) begin
        shift_nxt = ntt_pkg::sat_inc(shift_r);
      end else if (c == ntt_pkg::CH_UNDER) begin
        shift_nxt = ntt_pkg::sat_dec(shift_r);
      end else if (c == ntt_pkg::CH_PLUS) begin
        dbl_nxt = ntt_pkg::usat_inc(dbl_r);
      end else if (c == ntt_pkg::CH_MINUS) begin
        half_nxt = ntt_pkg::usat_inc(half_r);
      end else if (c == ntt_pkg::CH_TILDE) begin
        phrase_nxt = 1'b1;
      end else if (c == ntt_pkg::CH_HASH) begin
        acc_nxt = ntt_pkg::sat_inc(acc_r);
      end else if (c == ntt_pkg::CH_BANG) begin
        accent_nxt = 1'b1;
      end else if (c == ntt_pkg::CH_LB) begin
        flat_nxt = 1'b1;
      end else if (c inside {ntt_pkg::CH_DOT, ntt_pkg::CH_SPACE, ntt_pkg::CH_TAB,
                             ntt_pkg::CH_LF, ntt_pkg::CH_CR}) begin
        // ignored
      end else if (c inside {[ntt_pkg::CH_LA:ntt_pkg::CH_LZ]}) begin
        skip_nxt = 1'b1;
      end else begin
        emit           = 1'b1;
        res.token_kind = ntt_pkg::KIND_BAD;
        res.bad_char   = c;
      end
    end

    // tokens other than bad characters carry and then clear the record
    if (emit && res.token_kind != ntt_pkg::KIND_BAD) begin
      res.octave_shift = shift_r;
      res.double_count = dbl_r;
      res.half_count   = half_r;
      res.phrase_end   = phrase_r;
      res.accented     = accent_r;
      acc_nxt    = '0;
      shift_nxt  = '0;
      dbl_nxt    = '0;
      half_nxt   = '0;
      phrase_nxt = 1'b0;
      accent_nxt = 1'b0;
    end

    if (in_tlast) begin
      acc_nxt    = '0;
      shift_nxt  = '0;
      dbl_nxt    = '0;
      half_nxt   = '0;
      phrase_nxt = 1'b0;
      accent_nxt = 1'b0;
      flat_nxt   = 1'b0;
      skip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      shift_r  <= '0;
      dbl_r    <= '0;
      half_r   <= '0;
      phrase_r <= 1'b0;
      accent_r <= 1'b0;
      flat_r   <= 1'b0;
      skip_r   <= 1'b0;
    end else if (in_xfer) begin
      acc_r    <= acc_nxt;
      shift_r  <= shift_nxt;
      dbl_r    <= dbl_nxt;
      half_r   <= half_nxt;
      phrase_r <= phrase_nxt;
      accent_r <= accent_nxt;
      flat_r   <= flat_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // output register with one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_xfer) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_xfer && emit) begin
        if (!out_valid_r || out_xfer) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_r <= skid_r;
      end
    end else if (in_xfer && emit) begin
      if (!out_valid_r || out_xfer) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.token_kind;
  assign out_tlast  = 1'b1;
  assign out_tdata  = {out_r.bad_char, out_r.accented, out_r.phrase_end,
                       out_r.octave_number, out_r.half_count, out_r.double_count,
                       out_r.octave_shift, out_r.pitch_value};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> (!flat_r && !skip_r && acc_r == 4'sd0 && dbl_r == 4'd0))
    else $error("state not cleared after end of text");

  a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ntt_pkg::KIND_BAD) |-> (out_tdata[23:0] == 24'd0))
    else $error("unexpected-character token carries record fields");

  a_good_no_badchar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ntt_pkg::KIND_BAD) |-> (out_tdata[31:24] == 8'd0))
    else $error("token other than unexpected character carries bad_char");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid slot lost while receiver stalled");

endmodule

`default_nettype wire

>>> sim/note_text_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_text_tokenizer_top_tb
// Drives character streams into the notation tokenizer and checks every
// token against a cycle-independent prediction of the tokenizer. Directed
// texts hit the prefix marks, the flat/call decision, bad characters and
// text-end cleanup; random texts follow, mostly well-formed words with
// long mark runs for saturation, mixed with noise and broken sequences,
// under three source/sink idle profiles.
// ----------------------------------------------------------------------------

module note_text_tokenizer_top_tb;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // tokenizer state as predicted
  logic signed [3:0] acc_sum;
  logic signed [3:0] shift_sum;
  logic [3:0]        doubles;
  logic [3:0]        halves;
  logic              phrase_mark;
  logic              accent_mark;
  logic              flat_armed;
  logic              in_call;

  ntt_pkg::result_t pending_tokens[$];

  int src_idle_pct;
  int sink_idle_pct;
  int chars_counted;
  int errors;
  int quiet_cycles;
  int kind_seen[5];

  note_text_tokenizer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [3:0] sat4(input int v);
    if (v > ntt_pkg::S4_MAX) return ntt_pkg::S4_MAX;
    if (v < ntt_pkg::S4_MIN) return ntt_pkg::S4_MIN;
    return v[3:0];
  endfunction

  function automatic int semitone(input logic [7:0] c);
    case (c)
      ntt_pkg::CH_C: return 0;
      ntt_pkg::CH_D: return 2;
      ntt_pkg::CH_E: return 4;
      ntt_pkg::CH_F: return 5;
      ntt_pkg::CH_G: return 7;
      ntt_pkg::CH_A: return 9;
      default:       return 11;
    endcase
  endfunction

  function automatic void clear_marks();
    acc_sum     = '0;
    shift_sum   = '0;
    doubles     = '0;
    halves      = '0;
    phrase_mark = 1'b0;
    accent_mark = 1'b0;
  endfunction

  function automatic void queue_token(input ntt_pkg::result_t t);
    pending_tokens = {pending_tokens, t};
  endfunction

  function automatic void push_token(input logic [2:0] kind, input int pitch,
                                     input int octave);
    ntt_pkg::result_t t;
    t               = '0;
    t.token_kind    = kind;
    t.pitch_value   = pitch[5:0];
    t.octave_shift  = shift_sum;
    t.double_count  = doubles;
    t.half_count    = halves;
    t.octave_number = octave[3:0];
    t.phrase_end    = phrase_mark;
    t.accented      = accent_mark;
    queue_token(t);
    clear_marks();
  endfunction

  function automatic void tokenize_char(input logic [7:0] c, input logic eot);
    logic             plain;
    ntt_pkg::result_t bad;
    plain = 1'b1;
    if (in_call) begin
      if (c == ntt_pkg::CH_RPAREN) begin
        push_token(ntt_pkg::KIND_CALL, 0, 0);
        in_call = 1'b0;
      end
    end else begin
      if (flat_armed) begin
        flat_armed = 1'b0;
        if (c >= ntt_pkg::CH_A && c <= ntt_pkg::CH_Z) begin
          acc_sum = sat4(int'(acc_sum) - 1);
        end else begin
          plain = 1'b0;
          if (c == ntt_pkg::CH_RPAREN) push_token(ntt_pkg::KIND_CALL, 0, 0);
          else in_call = 1'b1;
        end
      end
      if (plain) begin
        if (c >= ntt_pkg::CH_A && c <= ntt_pkg::CH_G)
          push_token(ntt_pkg::KIND_NOTE, semitone(c) + int'(acc_sum), 0);
        else if (c == ntt_pkg::CH_R) push_token(ntt_pkg::KIND_REST, 0, 0);
        else if (c >= ntt_pkg::CH_0 && c <= ntt_pkg::CH_9)
          push_token(ntt_pkg::KIND_OCTAVE, 0, int'(c - ntt_pkg::CH_0));
        else if (c == ntt_pkg::CH_CARET) shift_sum = sat4(int'(shift_sum) + 1);
        else if (c == ntt_pkg::CH_UNDER) shift_sum = sat4(int'(shift_sum) - 1);
        else if (c == ntt_pkg::CH_PLUS) begin
          if (doubles != ntt_pkg::U4_MAX) doubles = doubles + 4'd1;
        end else if (c == ntt_pkg::CH_MINUS) begin
          if (halves != ntt_pkg::U4_MAX) halves = halves + 4'd1;
        end else if (c == ntt_pkg::CH_TILDE) phrase_mark = 1'b1;
        else if (c == ntt_pkg::CH_HASH) acc_sum = sat4(int'(acc_sum) + 1);
        else if (c == ntt_pkg::CH_BANG) accent_mark = 1'b1;
        else if (c == ntt_pkg::CH_LB) flat_armed = 1'b1;
        else if (c == ntt_pkg::CH_DOT || c == ntt_pkg::CH_SPACE || c == ntt_pkg::CH_TAB ||
                 c == ntt_pkg::CH_LF || c == ntt_pkg::CH_CR) begin
        end else if (c >= ntt_pkg::CH_LA && c <= ntt_pkg::CH_LZ) in_call = 1'b1;
        else begin
          // record survives a bad character
          bad            = '0;
          bad.token_kind = ntt_pkg::KIND_BAD;
          bad.bad_char   = c;
          queue_token(bad);
        end
      end
    end
    if (eot) begin
      clear_marks();
      flat_armed = 1'b0;
      in_call    = 1'b0;
    end
  endfunction

  initial begin
    clear_marks();
    flat_armed = 1'b0;
    in_call    = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tokenize_char(in_tdata, in_tlast);
  end

  // ------------------------------------------------------------------ checker

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    ntt_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: token with none expected: expected nothing, actual kind %0d data 0x%08h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        errors += field_diff("token_kind", 8'(want.token_kind), 8'(out_tuser));
        errors += field_diff("pitch_value", 8'($unsigned(want.pitch_value)),
                             8'(out_tdata[5:0]));
        errors += field_diff("octave_shift", 8'($unsigned(want.octave_shift)),
                             8'(out_tdata[9:6]));
        errors += field_diff("double_count", 8'(want.double_count), 8'(out_tdata[13:10]));
        errors += field_diff("half_count", 8'(want.half_count), 8'(out_tdata[17:14]));
        errors += field_diff("octave_number", 8'(want.octave_number), 8'(out_tdata[21:18]));
        errors += field_diff("phrase_end", 8'(want.phrase_end), 8'(out_tdata[22]));
        errors += field_diff("accented", 8'(want.accented), 8'(out_tdata[23]));
        errors += field_diff("bad_char", want.bad_char, out_tdata[31:24]);
        errors += field_diff("last", 8'd1, 8'(out_tlast));
        if (want.token_kind <= ntt_pkg::KIND_CALL) kind_seen[want.token_kind]++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d tokens outstanding",
                 $time, STALL_LIMIT, pending_tokens.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ------------------------------------------------------------------- sender

  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    chars_counted++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_rnd(input logic [7:0] c);
    send_char(c, $urandom_range(49) == 0);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0:       return ntt_pkg::CH_SPACE;
      1:       return ntt_pkg::CH_TAB;
      2:       return ntt_pkg::CH_LF;
      3:       return ntt_pkg::CH_CR;
      default: return ntt_pkg::CH_DOT;
    endcase
  endfunction

  task automatic send_mark(input int sel);
    case (sel)
      0: send_rnd(ntt_pkg::CH_HASH);
      1: send_rnd(ntt_pkg::CH_CARET);
      2: send_rnd(ntt_pkg::CH_UNDER);
      3: send_rnd(ntt_pkg::CH_PLUS);
      4: send_rnd(ntt_pkg::CH_MINUS);
      5: send_rnd(ntt_pkg::CH_TILDE);
      6: send_rnd(ntt_pkg::CH_BANG);
      7: begin
        // flat on a non-note capital: lowers the sum, leaves a rest or a bad char
        send_rnd(ntt_pkg::CH_LB);
        send_rnd(8'($urandom_range(ntt_pkg::CH_G + 1, ntt_pkg::CH_Z)));
      end
      8: send_rnd(blank_char());
      default: send_rnd(8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_call();
    int body;
    if ($urandom_range(1)) begin
      send_rnd(ntt_pkg::CH_LB);
      send_rnd(8'($urandom_range(ntt_pkg::CH_LA, ntt_pkg::CH_LZ)));
    end else begin
      send_rnd(8'($urandom_range(ntt_pkg::CH_LA, ntt_pkg::CH_LZ)));
    end
    body = $urandom_range(4);
    for (int i = 0; i < body; i++) send_rnd(8'($urandom_range(255)));
    send_rnd(ntt_pkg::CH_RPAREN);
  endtask

  task automatic send_word();
    bit long_run;
    int n_marks;
    int run_sel;
    int pick;
    long_run = ($urandom_range(5) == 0);
    n_marks  = long_run ? $urandom_range(10, 20) : $urandom_range(3);
    run_sel  = $urandom_range(7);
    for (int i = 0; i < n_marks; i++) send_mark(long_run ? run_sel : $urandom_range(9));
    pick = $urandom_range(11);
    if (pick <= 4) begin
      if ($urandom_range(3) == 0) send_rnd(ntt_pkg::CH_LB);
      send_rnd(8'($urandom_range(ntt_pkg::CH_A, ntt_pkg::CH_G)));
    end else if (pick == 5) begin
      send_rnd(ntt_pkg::CH_R);
    end else if (pick == 6) begin
      send_rnd(8'($urandom_range(ntt_pkg::CH_0, ntt_pkg::CH_9)));
    end else if (pick <= 9) begin
      send_call();
    end else if (pick == 10) begin
      send_rnd(8'($urandom_range(255)));
    end else begin
      send_rnd(ntt_pkg::CH_LB);
      send_rnd(8'($urandom_range(255)));
    end
    if ($urandom_range(11) == 0) send_char(blank_char(), 1'b1);
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_prefix_marks();
    send_text("^+-~!#A");
    send_text("R9");
    send_char(ntt_pkg::CH_0, 1'b1);
  endtask

  task automatic test_flat_decision();
    send_text("bB");
    send_text("bx)");
    send_text("b)");
  endtask

  task automatic test_unexpected_chars();
    send_char(ntt_pkg::CH_UNDER, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("\t.C");
  endtask

  task automatic test_text_end();
    send_text("q)");
    send_char(ntt_pkg::CH_LB, 1'b1);
    send_char(ntt_pkg::CH_LA + 8'd16, 1'b0);
    send_char(ntt_pkg::CH_HASH, 1'b1);
    send_char(ntt_pkg::CH_E, 1'b0);
  endtask

  task automatic test_random_text(input int n_chars);
    int start;
    start = chars_counted;
    while (chars_counted - start < n_chars) send_word();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    errors        = 0;
    chars_counted = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 13;
    sink_idle_pct = 78;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_prefix_marks();
    test_flat_decision();
    test_unexpected_chars();
    test_text_end();
    test_random_text(320);
    src_idle_pct  = 78;
    sink_idle_pct = 13;
    test_random_text(310);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_text(300);

    in_tvalid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d characters over directed texts and three idle profiles",
             chars_counted);
    $display("tokens checked: %0d notes, %0d rests, %0d octaves, %0d bad chars, %0d calls",
             kind_seen[ntt_pkg::KIND_NOTE], kind_seen[ntt_pkg::KIND_REST],
             kind_seen[ntt_pkg::KIND_OCTAVE], kind_seen[ntt_pkg::KIND_BAD],
             kind_seen[ntt_pkg::KIND_CALL]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
